FILE: src/channel_selector_with_favorites_assert.svh
// assertion macros for the channel selector checker
`ifndef CHANNEL_SELECTOR_WITH_FAVORITES_ASSERT_SVH
`define CHANNEL_SELECTOR_WITH_FAVORITES_ASSERT_SVH

// clocked check, held off while reset is high
`define CSF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define CSF_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/csf_pkg.sv
// shared widths, function codes and payload types of the channel selector
package csf_pkg;

   localparam int CHAN_W          = 7;
   localparam int FUNC_W          = 3;
   localparam int DIGIT_W         = 4;
   localparam int MAX_CHANNEL_DEF = 99;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_DIGIT        = 3'd0,
      FUNC_OK           = 3'd1,
      FUNC_FAV_TOGGLE   = 3'd2,
      FUNC_FAV_NEXT     = 3'd3,
      FUNC_SEARCH_START = 3'd4,
      FUNC_SEEK_FOUND   = 3'd5,
      FUNC_UP           = 3'd6,
      FUNC_DOWN         = 3'd7
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [DIGIT_W-1:0] digit;
      logic [CHAN_W-1:0]  found_channel;
   } req_item_type;

   typedef struct packed {
      logic              tune;
      logic [CHAN_W-1:0] channel;
      logic              entry_pending;
   } rsp_item_type;

endpackage

FILE: src/csf_if.sv
// valid/ready channel interfaces for key events and selector results
interface csf_req_if import csf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [DIGIT_W-1:0] digit;
   logic [CHAN_W-1:0]  found_channel;

   modport source (output valid, func, digit, found_channel, input ready);
   modport sink (input valid, func, digit, found_channel, output ready);
endinterface

interface csf_rsp_if import csf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              tune;
   logic [CHAN_W-1:0] channel;
   logic              entry_pending;

   modport source (output valid, tune, channel, entry_pending, input ready);
   modport sink (input valid, tune, channel, entry_pending, output ready);
endinterface

FILE: src/csf_scan.sv
// circular priority search for the next set channel above or below the current one
module csf_scan import csf_pkg::*; #(
   parameter int NUM = MAX_CHANNEL_DEF + 1
) (
   input  logic [NUM-1:0]    map,
   input  logic [CHAN_W-1:0] cur,
   input  logic              down,
   output logic              found,
   output logic [CHAN_W-1:0] idx
);

   localparam logic [CHAN_W-1:0] LAST = CHAN_W'(NUM - 1);

   logic [NUM-1:0]    rmap;
   logic [NUM-1:0]    above;
   logic [NUM-1:0]    pick;
   logic [NUM-1:0]    iso;
   logic [CHAN_W-1:0] rcur;
   logic [CHAN_W-1:0] pos;

   // searching downward is searching upward in the mirrored map
   always_comb begin
      rcur = down ? (LAST - cur) : cur;
      for (int i = 0; i < NUM; i++) begin
         rmap[i]  = down ? map[NUM-1-i] : map[i];
         above[i] = rmap[i] && (CHAN_W'(i) > rcur);
      end
      pick = (|above) ? above : rmap;
      // keep only the lowest set bit
      iso = pick & (~pick + {{(NUM-1){1'b0}}, 1'b1});
      pos = '0;
      for (int i = 0; i < NUM; i++) begin
         if (iso[i]) begin
            pos = pos | CHAN_W'(i);
         end
      end
   end

   assign found = |rmap;
   assign idx   = down ? (LAST - pos) : pos;

endmodule

FILE: src/csf_ctrl.sv
// selector state: current channel, held digit, favorites and searched maps
module csf_ctrl import csf_pkg::*; #(
   parameter int MAX_CHANNEL = MAX_CHANNEL_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam int NUM = MAX_CHANNEL + 1;
   localparam logic [CHAN_W-1:0] MAX_C = CHAN_W'(MAX_CHANNEL);

   logic [CHAN_W-1:0]  cur_ff, cur_in;
   logic [DIGIT_W-1:0] first_ff, first_in;
   logic               held_ff, held_in;
   logic [NUM-1:0]     fav_ff, fav_in;
   logic [NUM-1:0]     srch_ff, srch_in;

   logic [NUM-1:0]     scan_map;
   logic               scan_down;
   logic               scan_found;
   logic [CHAN_W-1:0]  scan_idx;
   logic [NUM-1:0]     cur_hot;
   logic [NUM-1:0]     found_hot;
   logic [CHAN_W-1:0]  first_ext;
   logic [CHAN_W-1:0]  two_digit;
   logic               tune;
   func_type           func;

   function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
      return (v > MAX_C) ? MAX_C : v;
   endfunction

   assign func      = func_type'(item.func);
   assign scan_map  = (func == FUNC_FAV_NEXT) ? fav_ff : srch_ff;
   assign scan_down = (func == FUNC_DOWN);

   csf_scan #(.NUM(NUM)) u_scan (
      .map   (scan_map),
      .cur   (cur_ff),
      .down  (scan_down),
      .found (scan_found),
      .idx   (scan_idx)
   );

   always_comb begin
      for (int i = 0; i < NUM; i++) begin
         cur_hot[i]   = (cur_ff == CHAN_W'(i));
         found_hot[i] = (item.found_channel == CHAN_W'(i));
      end
      first_ext = CHAN_W'(first_ff);
      // first * 10 + second
      two_digit = (first_ext << 3) + (first_ext << 1) + CHAN_W'(item.digit);
   end

   always_comb begin
      cur_in   = cur_ff;
      first_in = first_ff;
      held_in  = held_ff;
      fav_in   = fav_ff;
      srch_in  = srch_ff;
      tune     = 1'b0;
      case (func)
         FUNC_DIGIT: begin
            if (item.digit <= DIGIT_MAX) begin
               if (held_ff) begin
                  cur_in  = clamp_chan(two_digit);
                  tune    = 1'b1;
                  held_in = 1'b0;
               end else begin
                  first_in = item.digit;
                  held_in  = 1'b1;
               end
            end
         end
         FUNC_OK: begin
            if (held_ff) begin
               cur_in  = clamp_chan(first_ext);
               tune    = 1'b1;
               held_in = 1'b0;
            end
         end
         FUNC_FAV_TOGGLE: begin
            held_in = 1'b0;
            fav_in  = fav_ff ^ cur_hot;
         end
         FUNC_FAV_NEXT: begin
            held_in = 1'b0;
            if (scan_found) begin
               cur_in = scan_idx;
               tune   = 1'b1;
            end
         end
         FUNC_SEARCH_START: begin
            held_in = 1'b0;
            srch_in = '0;
         end
         FUNC_SEEK_FOUND: begin
            // not a key, a held digit stays
            if (item.found_channel <= MAX_C) begin
               srch_in = srch_ff | found_hot;
            end
         end
         FUNC_UP: begin
            held_in = 1'b0;
            tune    = 1'b1;
            if (scan_found) begin
               cur_in = scan_idx;
            end else begin
               cur_in = (cur_ff == MAX_C) ? '0 : cur_ff + CHAN_W'(1);
            end
         end
         FUNC_DOWN: begin
            held_in = 1'b0;
            tune    = 1'b1;
            if (scan_found) begin
               cur_in = scan_idx;
            end else begin
               cur_in = (cur_ff == '0) ? MAX_C : cur_ff - CHAN_W'(1);
            end
         end
         default: begin
            tune = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         first_ff <= '0;
         held_ff  <= 1'b0;
         fav_ff   <= '0;
         srch_ff  <= '0;
      end else if (step) begin
         cur_ff   <= cur_in;
         first_ff <= first_in;
         held_ff  <= held_in;
         fav_ff   <= fav_in;
         srch_ff  <= srch_in;
      end
   end

   assign result.tune          = tune;
   assign result.channel       = cur_in;
   assign result.entry_pending = held_in;

endmodule

FILE: src/channel_selector_with_favorites.sv
// top level of the channel selector: input register, state update, result register
//
//   channel | dir | carries
//   --------+-----+---------------------------------------------
//   req_bus | in  | func, digit, found_channel (key or seek event)
//   rsp_bus | out | tune, channel, entry_pending (one per event)
//
// one event per clock cycle unless rsp_bus stalls; rsp_bus is the result register
// the limiting combinational path is the circular search over the channel map
// reset (synchronous) clears the channel, held digit and both maps
// a stalled result holds; one more event waits in the input register
module channel_selector_with_favorites import csf_pkg::*; #(
   parameter int MAX_CHANNEL = MAX_CHANNEL_DEF
) (
   input logic      clock,
   input logic      reset,
   csf_req_if.sink  req_bus,
   csf_rsp_if.source rsp_bus
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         req_xfer;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   csf_ctrl #(.MAX_CHANNEL(MAX_CHANNEL)) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         in_item_ff.func          <= req_bus.func;
         in_item_ff.digit         <= req_bus.digit;
         in_item_ff.found_channel <= req_bus.found_channel;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.tune          = rsp_item_ff.tune;
   assign rsp_bus.channel       = rsp_item_ff.channel;
   assign rsp_bus.entry_pending = rsp_item_ff.entry_pending;

endmodule

FILE: src/csf_checker.sv
// port-level checks of the channel selector and their bind to the top level
`include "channel_selector_with_favorites_assert.svh"

module csf_checker import csf_pkg::*; #(
   parameter int MAX_CHANNEL = MAX_CHANNEL_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_tune,
   input logic [CHAN_W-1:0] rsp_channel,
   input logic              rsp_entry_pending
);

   localparam logic [CHAN_W-1:0] MAX_C = CHAN_W'(MAX_CHANNEL);

   // channel always stays inside the configured range
   `CSF_ASSERT(a_chan_range, rsp_valid |-> rsp_channel <= MAX_C, "channel out of range")
   // a tuning event always leaves no digit pending
   `CSF_ASSERT(a_tune_no_pending, rsp_valid && rsp_tune |-> !rsp_entry_pending, "tune with pending digit")
   // with the result side empty the input never stalls
   `CSF_ASSERT(a_req_open, !rsp_valid |-> req_ready, "input stalled with empty output")
   `CSF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel), "stalled result changed")
   `CSF_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind channel_selector_with_favorites csf_checker #(.MAX_CHANNEL(MAX_CHANNEL)) u_csf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_tune          (rsp_bus.tune),
   .rsp_channel       (rsp_bus.channel),
   .rsp_entry_pending (rsp_bus.entry_pending)
);
